FILE: src/deq_pkg.sv
// Shared constants and operation codes of the double-ended queue.
package deq_pkg;

    // Default number of ring entries.
    localparam int DEQ_DEPTH = 64;

    // Width of one stored value.
    localparam int DATA_W = 32;

    // Operation codes carried by the kind field.
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_LIST       = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

FILE: src/deq_ram.sv
// Ring store: one write port and one registered read port.
module deq_ram #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [deq_pkg::DATA_W-1:0]   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [deq_pkg::DATA_W-1:0]   o_rd_data
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write the entry.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read the entry; hold the data while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/double_ended_queue_unit.sv
// Top level of the double-ended queue: control, ring indices and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  input   | in        | i_valid / o_ready  | i_kind, i_value
//  output  | out       | o_valid / i_ready  | o_status, o_value_res, o_last
//
// A push, or any item that answers full or empty, goes straight to the result
// register; a pop waits in S_POP for the registered read port of the store. A list
// of n entries does one store read per entry, overlapped with handing the previous
// entry to the result register. Unused kind codes give no beat. Synchronous reset
// empties the queue at once; stored values are not cleared. A stalled output beat
// holds the block; a new item is taken in the cycle it drains.
module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [2:0]                         i_kind,
    input  logic signed [deq_pkg::DATA_W-1:0]  i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic signed [deq_pkg::DATA_W-1:0]  o_value_res,
    output logic                               o_last
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);
    localparam logic [SW-1:0] RING_LEN = SW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

    // Step one ring position forward.
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    // Step one ring position back.
    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - AW'(1);
    endfunction

    // Ring position base + off, with off below the ring length.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [OW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + SW'(off);
        if (sum >= RING_LEN) begin
            sum = sum - RING_LEN;
        end
        return sum[AW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [OW-1:0]   r_occ, n_occ;
    logic [AW-1:0]   r_addr, n_addr;
    logic [OW-1:0]   r_left, n_left;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_status, n_out_status;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic            r_out_last, n_out_last;

    logic              out_free;
    logic              in_take;
    logic              ram_we;
    logic [AW-1:0]     ram_wr_addr;
    logic              ram_re;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    deq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data ($unsigned(i_value)),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Result register is free when empty or drained this cycle.
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign in_take  = i_valid && o_ready;

    // Decode the operation and advance the ring.
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_occ        = r_occ;
        n_addr       = r_addr;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_wr_addr  = '0;
        ram_re       = 1'b0;
        ram_rd_addr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    unique case (i_kind) inside
                        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            n_out_value = '0;
                            n_out_last  = 1'b1;
                            if (r_occ == FULL_OCC) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_OK;
                                ram_we       = 1'b1;
                                n_occ        = r_occ + OW'(1);
                                if (i_kind == KIND_PUSH_FRONT) begin
                                    ram_wr_addr = ring_dec(r_front);
                                    n_front     = ring_dec(r_front);
                                end else begin
                                    ram_wr_addr = ring_add(r_front, r_occ);
                                end
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK, KIND_LIST: begin
                            if (r_occ == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                                n_out_value  = '0;
                                n_out_last   = 1'b1;
                            end else if (i_kind == KIND_POP_FRONT) begin
                                ram_re      = 1'b1;
                                ram_rd_addr = r_front;
                                n_front     = ring_inc(r_front);
                                n_occ       = r_occ - OW'(1);
                                n_state     = S_POP;
                            end else if (i_kind == KIND_POP_BACK) begin
                                ram_re      = 1'b1;
                                ram_rd_addr = ring_add(r_front, r_occ - OW'(1));
                                n_occ       = r_occ - OW'(1);
                                n_state     = S_POP;
                            end else begin
                                ram_re      = 1'b1;
                                ram_rd_addr = r_front;
                                n_addr      = ring_inc(r_front);
                                n_left      = r_occ;
                                n_state     = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                // Hand the popped value to the result register.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_value  = ram_rd_data;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LIST: begin
                // Emit the entry just read and fetch the next one.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_value  = ram_rd_data;
                    n_out_last   = (r_left == OW'(1));
                    if (r_left == OW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re      = 1'b1;
                        ram_rd_addr = r_addr;
                        n_addr      = ring_inc(r_addr);
                        n_left      = r_left - OW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, ring indices and the result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
        r_addr       <= n_addr;
        r_left       <= n_left;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value_res = $signed(r_out_value);
    assign o_last      = r_out_last;

endmodule
